>>> design/ps2mpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared widths, register map, reset values and types.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  localparam int unsigned POS_BITS   = 12;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CALC_W     = ((POS_BITS > COORD_W) ? POS_BITS : COORD_W) + 2;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd1024;
  localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd768;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               left_down;
    logic               right_down;
    logic               left_released;
    logic               right_released;
    logic               packet_done;
  } res_t;

endpackage
`default_nettype wire

>>> design/ps2mpt_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker configuration registers
// APB-style screen width and height registers; pready is tied high.
// ----------------------------------------------------------------------------
module ps2mpt_apb_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ps2mpt_pkg::APB_AW-1:0] paddr,
  input  wire logic [ps2mpt_pkg::APB_DW-1:0] pwdata,
  output logic      [ps2mpt_pkg::APB_DW-1:0] prdata,
  output logic                               pready,
  output logic      [ps2mpt_pkg::COORD_W-1:0] width_o,
  output logic      [ps2mpt_pkg::COORD_W-1:0] height_o
);
  import ps2mpt_pkg::*;

  logic [COORD_W-1:0] width_q, width_d;
  logic [COORD_W-1:0] height_q, height_d;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    unique case (idx)
      REG_WIDTH: begin
        if (wr_en) width_d = pwdata[COORD_W-1:0];
        prdata = APB_DW'(width_q);
      end
      REG_HEIGHT: begin
        if (wr_en) height_d = pwdata[COORD_W-1:0];
        prdata = APB_DW'(height_q);
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule
`default_nettype wire

>>> design/ps2mpt_pkt_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker engine
// Byte alignment, packet capture, cursor add-and-clamp and button tracking.
// ----------------------------------------------------------------------------
module ps2mpt_pkt_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           fire_i,
  input  wire logic [7:0]                     byte_i,
  input  wire logic [ps2mpt_pkg::COORD_W-1:0] width_i,
  input  wire logic [ps2mpt_pkg::COORD_W-1:0] height_i,
  output ps2mpt_pkg::res_t                    res_o
);
  import ps2mpt_pkg::*;

  phase_e                    phase_q, phase_d;
  logic [7:0]                first_q, first_d;
  logic [7:0]                second_q, second_d;
  logic [POS_BITS-1:0]       cur_x_q, cur_x_d;
  logic [POS_BITS-1:0]       cur_y_q, cur_y_d;
  logic                      left_q, left_d;
  logic                      right_q, right_d;
  logic                      lrel_q, lrel_d;
  logic                      rrel_q, rrel_d;
  logic                      done;
  logic signed [8:0]         dx, dy;
  logic signed [CALC_W-1:0]  x_sum, y_sum, w_ext, h_ext;
  logic [POS_BITS-1:0]       x_clamp, y_clamp;

  assign dx    = $signed({first_q[4], second_q});
  assign dy    = $signed({first_q[5], byte_i});
  assign x_sum = $signed(CALC_W'(cur_x_q)) + CALC_W'(dx);
  assign y_sum = $signed(CALC_W'(cur_y_q)) - CALC_W'(dy);
  assign w_ext = $signed(CALC_W'(width_i));
  assign h_ext = $signed(CALC_W'(height_i));

  always_comb begin
    if (x_sum >= w_ext) begin
      x_clamp = (width_i != '0) ? POS_BITS'(width_i - 12'd1) : '0;
    end else if (x_sum < 0) begin
      x_clamp = '0;
    end else begin
      x_clamp = POS_BITS'(x_sum);
    end
    if (y_sum >= h_ext) begin
      y_clamp = (height_i >= 12'd2) ? POS_BITS'(height_i - 12'd2) : '0;
    end else if (y_sum < 0) begin
      y_clamp = '0;
    end else begin
      y_clamp = POS_BITS'(y_sum);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    left_d   = left_q;
    right_d  = right_q;
    lrel_d   = lrel_q;
    rrel_d   = rrel_q;
    done     = 1'b0;
    if (fire_i) begin
      unique case (phase_q)
        PH_SECOND: begin
          second_d = byte_i;
          phase_d  = PH_THIRD;
        end
        PH_THIRD: begin
          phase_d = PH_FIRST;
          done    = 1'b1;
          cur_x_d = x_clamp;
          cur_y_d = y_clamp;
          left_d  = first_q[0];
          right_d = first_q[1];
          lrel_d  = ~first_q[0] & left_q;
          rrel_d  = ~first_q[1] & right_q;
        end
        default: begin
          // resync: only a byte with bit 3 set opens a packet
          phase_d = PH_FIRST;
          if (byte_i[3]) begin
            first_d = byte_i;
            phase_d = PH_SECOND;
          end
        end
      endcase
    end
    res_o = '{pos_x:          COORD_W'(cur_x_d),
              pos_y:          COORD_W'(cur_y_d),
              left_down:      left_d,
              right_down:     right_d,
              left_released:  lrel_d,
              right_released: rrel_d,
              packet_done:    done};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      cur_x_q <= '0;
      cur_y_q <= '0;
      left_q  <= 1'b0;
      right_q <= 1'b0;
      lrel_q  <= 1'b0;
      rrel_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      left_q  <= left_d;
      right_q <= right_d;
      lrel_q  <= lrel_d;
      rrel_q  <= rrel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

endmodule
`default_nettype wire

>>> design/ps2_mouse_packet_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Decodes a three-byte PS/2 mouse stream into cursor position and buttons.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the rx channel (rx_valid_i/rx_ready_o/rx_byte_i); every
//   accepted byte yields exactly one result on the res channel, carrying the
//   cursor position, button state, release flags and packet_done.
//   Path: each byte passes the input register, then its result waits in the
//   result register until taken.
//   Throughput: one byte per cycle while results are taken or the result
//   stage is empty; the add-and-clamp between the two registers is a single pass.
//   Stall: while a result waits, the input register still takes one more
//   request; rx_ready_o then drops until res_ready_i frees the result stage.
//   Reset: both stages empty, cursor at 0,0, buttons released, alignment
//   waiting for a first byte, width 1024 and height 768.
//   Configuration: APB writes to width (0x0) and height (0x4) while idle.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           rx_valid_i,
  output logic                                rx_ready_o,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output logic      [ps2mpt_pkg::COORD_W-1:0] pos_x_o,
  output logic      [ps2mpt_pkg::COORD_W-1:0] pos_y_o,
  output logic                                left_down_o,
  output logic                                right_down_o,
  output logic                                left_released_o,
  output logic                                right_released_o,
  output logic                                packet_done_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ps2mpt_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ps2mpt_pkg::APB_DW-1:0]  pwdata,
  output logic      [ps2mpt_pkg::APB_DW-1:0]  prdata,
  output logic                                pready
);
  import ps2mpt_pkg::*;

  logic               in_valid_q, in_valid_d;
  logic [7:0]         in_byte_q;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, eng_res;
  logic               advance;
  logic [COORD_W-1:0] width, height;

  ps2mpt_apb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_o  (width),
    .height_o (height)
  );

  ps2mpt_pkt_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_valid_q & advance),
    .byte_i   (in_byte_q),
    .width_i  (width),
    .height_i (height),
    .res_o    (eng_res)
  );

  assign advance     = ~res_valid_q | res_ready_i;
  assign rx_ready_o  = ~in_valid_q | advance;
  assign in_valid_d  = rx_ready_o ? rx_valid_i : in_valid_q;
  assign res_valid_d = advance ? in_valid_q : res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o) in_byte_q <= rx_byte_i;
    if (advance && in_valid_q) res_q <= eng_res;
  end

  assign res_valid_o      = res_valid_q;
  assign pos_x_o          = res_q.pos_x;
  assign pos_y_o          = res_q.pos_y;
  assign left_down_o      = res_q.left_down;
  assign right_down_o     = res_q.right_down;
  assign left_released_o  = res_q.left_released;
  assign right_released_o = res_q.right_released;
  assign packet_done_o    = res_q.packet_done;

endmodule
`default_nettype wire

>>> design/ps2mpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ps2mpt_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           res_valid_o,
  input wire logic                           res_ready_i,
  input wire logic [ps2mpt_pkg::COORD_W-1:0] pos_x_o,
  input wire logic [ps2mpt_pkg::COORD_W-1:0] pos_y_o,
  input wire logic                           left_down_o,
  input wire logic                           right_down_o,
  input wire logic                           left_released_o,
  input wire logic                           right_released_o,
  input wire logic                           packet_done_o
);
  import ps2mpt_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result request dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=>
      $stable(pos_x_o) && $stable(pos_y_o) && $stable(packet_done_o))
    else $error("result payload changed while stalled");

  a_left_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(left_down_o && left_released_o))
    else $error("left button both held and released");

  a_right_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(right_down_o && right_released_o))
    else $error("right button both held and released");

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_o      (res_valid_o),
  .res_ready_i      (res_ready_i),
  .pos_x_o          (pos_x_o),
  .pos_y_o          (pos_y_o),
  .left_down_o      (left_down_o),
  .right_down_o     (right_down_o),
  .left_released_o  (left_released_o),
  .right_released_o (right_released_o),
  .packet_done_o    (packet_done_o)
);
`default_nettype wire
